// File: rtl/core/pooled_cursor_list_manager_core_defines.svh
// Assertion macros used by the pooled cursor list manager datapath.
`ifndef POOLED_CURSOR_LIST_MANAGER_CORE_DEFINES_SVH
`define POOLED_CURSOR_LIST_MANAGER_CORE_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define PCLM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pclm implication check failed");
// Invariant checked at every clock edge outside reset.
`define PCLM_ASSERT_HOLDS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("pclm invariant check failed");
`endif

// File: rtl/core/pclm_pkg.sv
// Types, codes and constants of the pooled cursor list manager.
`default_nettype none
package pclm_pkg;
  localparam int unsigned NODES_DEF = 256;
  localparam int unsigned HEADS = 16;
  localparam int unsigned HID_W = 4;
  localparam int unsigned HEAD_W = 5;
  localparam int unsigned ITEM_W = 32;
  localparam int unsigned CNT_W = 9;

  localparam logic [3:0] CMD_CREATE = 4'd0;
  localparam logic [3:0] CMD_COUNT = 4'd1;
  localparam logic [3:0] CMD_FIRST = 4'd2;
  localparam logic [3:0] CMD_LAST = 4'd3;
  localparam logic [3:0] CMD_NEXT = 4'd4;
  localparam logic [3:0] CMD_PREV = 4'd5;
  localparam logic [3:0] CMD_CURR = 4'd6;
  localparam logic [3:0] CMD_INS_AFTER = 4'd7;
  localparam logic [3:0] CMD_INS_BEFORE = 4'd8;
  localparam logic [3:0] CMD_APPEND = 4'd9;
  localparam logic [3:0] CMD_PREPEND = 4'd10;
  localparam logic [3:0] CMD_REMOVE = 4'd11;
  localparam logic [3:0] CMD_TRIM = 4'd12;
  localparam logic [3:0] CMD_CONCAT = 4'd13;
  localparam logic [3:0] CMD_FREE = 4'd14;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_POOL_EMPTY = 2'd1;
  localparam logic [1:0] ST_NO_HEAD = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  localparam logic [1:0] SIDE_IN = 2'd0;
  localparam logic [1:0] SIDE_BEFORE = 2'd1;
  localparam logic [1:0] SIDE_AFTER = 2'd2;

  localparam logic [1:0] AT_FRONT = 2'd0;
  localparam logic [1:0] AT_BACK = 2'd1;
  localparam logic [1:0] AT_AFTER = 2'd2;
  localparam logic [1:0] AT_BEFORE = 2'd3;

  typedef struct packed {
    logic [3:0] command;
    logic [HID_W-1:0] list_id;
    logic [HID_W-1:0] other_list;
    logic [ITEM_W-1:0] item;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [ITEM_W-1:0] item_out;
    logic [HID_W-1:0] handle_out;
    logic [CNT_W-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic init;
    logic capture;
    logic load;
    logic rd1;
    logic rd2;
    logic rd3;
    logic w1;
    logic w2;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic init_done;
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/core/pclm_ctrl.sv
// Command sequencer of the pooled cursor list manager.
`default_nettype none
module pclm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire pclm_pkg::stat_t stat,
  output pclm_pkg::ctl_t      ctl
);
  import pclm_pkg::*;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LOAD = 4'd2;
  localparam logic [3:0] S_RD1 = 4'd3;
  localparam logic [3:0] S_RD2 = 4'd4;
  localparam logic [3:0] S_RD3 = 4'd5;
  localparam logic [3:0] S_W1 = 4'd6;
  localparam logic [3:0] S_W2 = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (stat.init_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_LOAD;
      end
      S_LOAD: state_next = S_RD1;
      S_RD1: state_next = S_RD2;
      S_RD2: state_next = S_RD3;
      S_RD3: state_next = S_W1;
      S_W1: state_next = S_W2;
      S_W2: state_next = S_COMMIT;
      S_COMMIT: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    ctl = '0;
    ctl.init = (state == S_INIT) && !stat.init_done;
    ctl.capture = (state == S_IDLE) && req_valid;
    ctl.load = (state == S_LOAD);
    ctl.rd1 = (state == S_RD1);
    ctl.rd2 = (state == S_RD2);
    ctl.rd3 = (state == S_RD3);
    ctl.w1 = (state == S_W1);
    ctl.w2 = (state == S_W2);
    ctl.commit = (state == S_COMMIT) && !stat.out_busy;
  end
endmodule
`default_nettype wire

// File: rtl/core/pclm_datapath.sv
// Node memories, list table, head stack and result register.
`default_nettype none
`include "pooled_cursor_list_manager_core_defines.svh"
module pclm_datapath #(
  parameter int unsigned NODES = pclm_pkg::NODES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pclm_pkg::ctl_t ctl,
  output pclm_pkg::stat_t     stat,
  input  wire pclm_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output pclm_pkg::rsp_t      rsp
);
  import pclm_pkg::*;

  localparam int unsigned AW = $clog2(NODES);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam logic [NW-1:0] NONE = NW'(NODES);
  localparam logic [HEAD_W-1:0] NONE_H = HEAD_W'(HEADS);

  // node memories
  logic [NW-1:0] mem_next [NODES];
  logic [NW-1:0] mem_prev [NODES];
  logic [ITEM_W-1:0] mem_item [NODES];
  logic [NW-1:0] nrd, prd;
  logic [ITEM_W-1:0] ird;

  logic n_we, p_we, i_we;
  logic [AW-1:0] n_wa, p_wa, i_wa, n_ra, p_ra, i_ra;
  logic [NW-1:0] n_wd, p_wd;

  // list table and head stack
  logic [NW-1:0] list_start [HEADS];
  logic [NW-1:0] list_end [HEADS];
  logic [NW-1:0] list_cursor [HEADS];
  logic [CW-1:0] list_size [HEADS];
  logic [1:0] list_oob [HEADS];
  logic [HEADS-1:0] head_used;
  logic [HEAD_W-1:0] head_next_free [HEADS];
  logic [HEAD_W-1:0] head_free_top;
  logic [NW-1:0] pool_head;
  logic [CW-1:0] pool_count;

  // clearing pass
  logic [NW-1:0] init_idx;
  logic init_done;

  // command and working registers
  logic [3:0] cmd;
  logic [HID_W-1:0] h, g;
  logic [ITEM_W-1:0] itm;
  logic [NW-1:0] ls, le, lc, gs, ge;
  logic [CW-1:0] lsz, gsz;
  logic [1:0] loob;
  logic live, gok;
  logic [NW-1:0] t_a, t_b, t_pnext;
  logic [ITEM_W-1:0] t_item;

  logic out_valid;
  rsp_t out_data;

  // decode
  logic is_ins, is_move, fwd, in_b, a_ok, b_ok;
  logic ok_ins, ok_rem, ok_trim, ok_cat, ok_free;
  logic [1:0] far_side, near_side, where;
  logic [NW-1:0] dest, nn_next, nn_prev;

  always_comb begin
    is_ins = (cmd == CMD_INS_AFTER) || (cmd == CMD_INS_BEFORE) ||
             (cmd == CMD_APPEND) || (cmd == CMD_PREPEND);
    is_move = (cmd == CMD_NEXT) || (cmd == CMD_PREV);
    fwd = (cmd == CMD_NEXT);
    far_side = fwd ? SIDE_AFTER : SIDE_BEFORE;
    near_side = fwd ? SIDE_BEFORE : SIDE_AFTER;
    in_b = (lsz != '0) && (loob == SIDE_IN);
    a_ok = (t_a != NONE);
    b_ok = (t_b != NONE);
    ok_ins = live && is_ins && (pool_count != '0) && (pool_head != NONE);
    ok_rem = live && (cmd == CMD_REMOVE) && in_b;
    ok_trim = live && (cmd == CMD_TRIM) && (lsz != '0);
    ok_cat = live && (cmd == CMD_CONCAT) && gok;
    ok_free = live && (cmd == CMD_FREE);
    if ((lsz == '0) || (loob == far_side)) begin
      dest = NONE;
    end else if (loob == near_side) begin
      dest = fwd ? ls : le;
    end else begin
      dest = fwd ? nrd : prd;
    end
    if (cmd == CMD_APPEND) where = AT_BACK;
    else if (cmd == CMD_PREPEND) where = AT_FRONT;
    else if (loob == SIDE_BEFORE) where = AT_FRONT;
    else if (loob == SIDE_AFTER) where = AT_BACK;
    else if (cmd == CMD_INS_AFTER) where = AT_AFTER;
    else where = AT_BEFORE;
    nn_next = NONE;
    nn_prev = NONE;
    if (lsz != '0) begin
      case (where)
        AT_FRONT: nn_next = ls;
        AT_BACK: nn_prev = le;
        AT_AFTER: begin
          nn_next = t_a;
          nn_prev = lc;
        end
        AT_BEFORE: begin
          nn_next = lc;
          nn_prev = t_b;
        end
        default: nn_next = NONE;
      endcase
    end
  end

  // memory port selection
  always_comb begin
    n_we = 1'b0;
    p_we = 1'b0;
    i_we = 1'b0;
    n_wa = '0;
    p_wa = '0;
    i_wa = pool_head[AW-1:0];
    n_wd = NONE;
    p_wd = NONE;
    n_ra = (ctl.rd2 || !is_ins) ? lc[AW-1:0] : pool_head[AW-1:0];
    p_ra = (cmd == CMD_TRIM) ? le[AW-1:0] : lc[AW-1:0];
    if (ctl.rd2) i_ra = dest[AW-1:0];
    else if (cmd == CMD_FIRST) i_ra = ls[AW-1:0];
    else if ((cmd == CMD_LAST) || (cmd == CMD_TRIM)) i_ra = le[AW-1:0];
    else i_ra = lc[AW-1:0];
    if (ctl.init) begin
      n_we = 1'b1;
      n_wa = init_idx[AW-1:0];
      n_wd = NW'(init_idx + 1'b1);
      p_we = 1'b1;
      p_wa = init_idx[AW-1:0];
    end else if (ctl.w1) begin
      if (ok_ins) begin
        n_we = 1'b1;
        n_wa = pool_head[AW-1:0];
        n_wd = nn_next;
        p_we = 1'b1;
        p_wa = pool_head[AW-1:0];
        p_wd = nn_prev;
        i_we = 1'b1;
      end else if (ok_rem) begin
        n_we = b_ok;
        n_wa = t_b[AW-1:0];
        n_wd = t_a;
        p_we = a_ok;
        p_wa = t_a[AW-1:0];
        p_wd = t_b;
      end else if (ok_trim) begin
        n_we = b_ok;
        n_wa = t_b[AW-1:0];
      end else if (ok_cat) begin
        n_we = (gsz != '0) && (lsz != '0);
        n_wa = le[AW-1:0];
        n_wd = gs;
        p_we = (gsz != '0) && (lsz != '0);
        p_wa = gs[AW-1:0];
        p_wd = le;
      end else if (ok_free) begin
        n_we = (lsz != '0);
        n_wa = le[AW-1:0];
        n_wd = pool_head;
        p_we = (lsz != '0);
        p_wa = ls[AW-1:0];
      end
    end else if (ctl.w2) begin
      if (ok_ins && (lsz != '0)) begin
        n_wd = pool_head;
        p_wd = pool_head;
        case (where)
          AT_FRONT: begin
            p_we = 1'b1;
            p_wa = ls[AW-1:0];
          end
          AT_BACK: begin
            n_we = 1'b1;
            n_wa = le[AW-1:0];
          end
          AT_AFTER: begin
            n_we = 1'b1;
            n_wa = lc[AW-1:0];
            p_we = a_ok;
            p_wa = t_a[AW-1:0];
          end
          AT_BEFORE: begin
            p_we = 1'b1;
            p_wa = lc[AW-1:0];
            n_we = b_ok;
            n_wa = t_b[AW-1:0];
          end
          default: n_we = 1'b0;
        endcase
      end else if (ok_rem || ok_trim) begin
        n_we = 1'b1;
        n_wa = ok_rem ? lc[AW-1:0] : le[AW-1:0];
        n_wd = pool_head;
        p_we = 1'b1;
        p_wa = ok_rem ? lc[AW-1:0] : le[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (n_we) mem_next[n_wa] <= n_wd;
    if (p_we) mem_prev[p_wa] <= p_wd;
    if (i_we) mem_item[i_wa] <= itm;
    nrd <= mem_next[n_ra];
    prd <= mem_prev[p_ra];
    ird <= mem_item[i_ra];
  end

  // commit values
  logic [NW-1:0] r_start, r_end, r_cur, ph_next;
  logic [CW-1:0] r_size, pc_next;
  logic [1:0] r_oob, r_status;
  logic [ITEM_W-1:0] r_item;
  logic [HID_W-1:0] r_handle;
  logic [CNT_W-1:0] r_cnt;

  always_comb begin
    r_start = ls;
    r_end = le;
    r_cur = lc;
    r_size = lsz;
    r_oob = loob;
    r_status = ST_OK;
    r_item = '0;
    r_handle = '0;
    ph_next = pool_head;
    pc_next = pool_count;
    if (cmd == CMD_CREATE) begin
      if (head_free_top == NONE_H) r_status = ST_NO_HEAD;
      else r_handle = head_free_top[HID_W-1:0];
    end else if (!live) begin
      r_status = ST_NONE;
    end else begin
      case (cmd)
        CMD_COUNT: r_status = ST_OK;
        CMD_FIRST, CMD_LAST: begin
          if (lsz == '0) begin
            r_status = ST_NONE;
          end else begin
            r_cur = (cmd == CMD_FIRST) ? ls : le;
            r_oob = SIDE_IN;
            r_item = t_item;
          end
        end
        CMD_NEXT, CMD_PREV: begin
          if (!a_ok) begin
            r_cur = NONE;
            r_oob = far_side;
            r_status = ST_NONE;
          end else begin
            r_cur = t_a;
            r_oob = SIDE_IN;
            r_item = t_item;
          end
        end
        CMD_CURR: begin
          if (in_b) r_item = t_item;
          else r_status = ST_NONE;
        end
        CMD_INS_AFTER, CMD_INS_BEFORE, CMD_APPEND, CMD_PREPEND: begin
          if (!ok_ins) begin
            r_status = ST_POOL_EMPTY;
          end else begin
            if (lsz == '0) begin
              r_start = pool_head;
              r_end = pool_head;
            end else begin
              case (where)
                AT_FRONT: r_start = pool_head;
                AT_BACK: r_end = pool_head;
                AT_AFTER: begin
                  if (!a_ok) r_end = pool_head;
                end
                AT_BEFORE: begin
                  if (!b_ok) r_start = pool_head;
                end
                default: r_start = ls;
              endcase
            end
            r_size = lsz + 1'b1;
            r_cur = pool_head;
            r_oob = SIDE_IN;
            ph_next = t_pnext;
            pc_next = pool_count - 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (!in_b) begin
            r_status = ST_NONE;
          end else begin
            if (!b_ok) r_start = t_a;
            if (!a_ok) begin
              r_end = t_b;
              r_cur = NONE;
              r_oob = SIDE_AFTER;
            end else begin
              r_cur = t_a;
            end
            r_size = lsz - 1'b1;
            r_item = t_item;
            ph_next = lc;
            pc_next = pool_count + 1'b1;
          end
        end
        CMD_TRIM: begin
          if (lsz == '0) begin
            r_status = ST_NONE;
          end else begin
            if (!b_ok) r_start = NONE;
            r_end = t_b;
            r_size = lsz - 1'b1;
            if (lsz == CW'(1)) begin
              r_cur = NONE;
              r_oob = SIDE_BEFORE;
            end else begin
              r_cur = t_b;
              r_oob = SIDE_IN;
            end
            r_item = t_item;
            ph_next = le;
            pc_next = pool_count + 1'b1;
          end
        end
        CMD_CONCAT: begin
          if (!gok) begin
            r_status = ST_NONE;
          end else if (gsz != '0) begin
            if (lsz == '0) r_start = gs;
            r_end = ge;
            r_size = lsz + gsz;
          end
        end
        CMD_FREE: begin
          if (lsz != '0) begin
            ph_next = ls;
            pc_next = pool_count + lsz;
          end
        end
        default: r_status = ST_NONE;
      endcase
    end
    if ((cmd != CMD_CREATE) && (cmd != CMD_FREE) && live) r_cnt = CNT_W'(r_size);
    else r_cnt = '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd <= req.command;
      h <= req.list_id;
      g <= req.other_list;
      itm <= req.item;
    end
    if (ctl.load) begin
      ls <= list_start[h];
      le <= list_end[h];
      lc <= list_cursor[h];
      lsz <= list_size[h];
      loob <= list_oob[h];
    end
    if (ctl.rd1) begin
      gs <= list_start[g];
      ge <= list_end[g];
      gsz <= list_size[g];
    end
    if (ctl.rd2) begin
      t_a <= is_move ? dest : nrd;
      t_b <= prd;
      t_pnext <= nrd;
      t_item <= ird;
    end
    if (ctl.rd3) begin
      if (is_move) t_item <= ird;
      if (is_ins) t_a <= nrd;
    end
    if (ctl.commit) begin
      out_data.status <= r_status;
      out_data.item_out <= r_item;
      out_data.handle_out <= r_handle;
      out_data.count <= r_cnt;
    end
  end

  // control state: table, stack, pool, handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HEADS; i++) begin
        list_start[i] <= NONE;
        list_end[i] <= NONE;
        list_cursor[i] <= NONE;
        list_size[i] <= '0;
        list_oob[i] <= SIDE_BEFORE;
        head_next_free[i] <= HEAD_W'(i + 1);
      end
      head_used <= '0;
      head_free_top <= '0;
      pool_head <= '0;
      pool_count <= CW'(NODES);
      init_idx <= '0;
      init_done <= 1'b0;
      out_valid <= 1'b0;
      live <= 1'b0;
      gok <= 1'b0;
    end else begin
      if (ctl.init) begin
        init_idx <= NW'(init_idx + 1'b1);
        init_done <= (init_idx == NW'(NODES - 1));
      end
      if (ctl.load) live <= head_used[h];
      if (ctl.rd1) gok <= (g != h) && head_used[g];
      if (ctl.w1 && ok_cat) begin
        list_start[g] <= NONE;
        list_end[g] <= NONE;
        list_cursor[g] <= NONE;
        list_size[g] <= '0;
        list_oob[g] <= SIDE_BEFORE;
      end
      if (ctl.commit) begin
        pool_head <= ph_next;
        pool_count <= pc_next;
        if (cmd == CMD_CREATE) begin
          if (head_free_top != NONE_H) begin
            list_start[head_free_top[HID_W-1:0]] <= NONE;
            list_end[head_free_top[HID_W-1:0]] <= NONE;
            list_cursor[head_free_top[HID_W-1:0]] <= NONE;
            list_size[head_free_top[HID_W-1:0]] <= '0;
            list_oob[head_free_top[HID_W-1:0]] <= SIDE_BEFORE;
            head_used[head_free_top[HID_W-1:0]] <= 1'b1;
            head_free_top <= head_next_free[head_free_top[HID_W-1:0]];
          end
        end else if (ok_free) begin
          list_start[h] <= NONE;
          list_end[h] <= NONE;
          list_cursor[h] <= NONE;
          list_size[h] <= '0;
          list_oob[h] <= SIDE_BEFORE;
          head_used[h] <= 1'b0;
          head_next_free[h] <= head_free_top;
          head_free_top <= {1'b0, h};
        end else if (live) begin
          list_start[h] <= r_start;
          list_end[h] <= r_end;
          list_cursor[h] <= r_cur;
          list_size[h] <= r_size;
          list_oob[h] <= r_oob;
          if (ok_cat) begin
            head_used[g] <= 1'b0;
            head_next_free[g] <= head_free_top;
            head_free_top <= {1'b0, g};
          end
        end
      end
      if (ctl.commit) out_valid <= 1'b1;
      else if (rsp_ready) out_valid <= 1'b0;
    end
  end

  assign stat.init_done = init_done;
  assign stat.out_busy = out_valid && !rsp_ready;
  assign rsp_valid = out_valid;
  assign rsp = out_data;

  `PCLM_ASSERT_HOLDS(a_pool_bound, pool_count <= CW'(NODES))
  `PCLM_ASSERT_IMP(a_pool_empty, pool_head == NONE, pool_count == '0)
  `PCLM_ASSERT_IMP(a_heads_full, head_free_top == NONE_H, &head_used)
endmodule
`default_nettype wire

// File: rtl/core/pooled_cursor_list_manager_core.sv
// Top level of the pooled cursor list manager: sequencer plus datapath.
//
//   channel | beat      | handshake
//   req     | command   | req_valid / req_ready
//   rsp     | result    | rsp_valid / rsp_ready
//
// Every command steps through the load, rd1, rd2, rd3, w1, w2 and commit
// states before its result is registered; req_ready stays low until it has
// committed, so commands never overlap. Dependent registered node-memory
// reads and the w1/w2 writes on the single-write-port node memories set that order.
// After reset a clearing pass over all NODES nodes builds the free-node chain;
// req_ready rises once that pass is done.
// A result not yet taken holds the next command in its commit cycle.
`default_nettype none
module pooled_cursor_list_manager_core #(
  parameter int unsigned NODES = pclm_pkg::NODES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire pclm_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output pclm_pkg::rsp_t      rsp
);
  import pclm_pkg::*;

  ctl_t ctl;
  stat_t stat;

  pclm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  pclm_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );
endmodule
`default_nettype wire

// File: dv/pooled_cursor_list_manager_core_tb.sv
// Self-checking testbench for the pooled cursor list manager core.
`timescale 1ns / 1ps
`default_nettype none

class list_scoreboard;
  localparam int NN = 256;
  localparam int NH = 16;

  logic [31:0] n_item [NN];
  int n_next [NN];
  int n_prev [NN];
  int pool_top, pool_cnt;
  int l_start [NH], l_end [NH], l_cur [NH], l_size [NH];
  logic [1:0] l_side [NH];
  int h_next [NH];
  int h_top;
  bit h_live [NH];
  pclm_pkg::rsp_t pending [$];
  int errors;

  function new();
    errors = 0;
    for (int i = 0; i < NN; i++) begin
      n_item[i] = '0; n_next[i] = i + 1; n_prev[i] = NN;
    end
    pool_top = 0; pool_cnt = NN;
    for (int i = 0; i < NH; i++) begin
      wipe(i); h_live[i] = 0; h_next[i] = i + 1;
    end
    h_top = 0;
  endfunction

  function void wipe(int h);
    l_start[h] = NN; l_end[h] = NN; l_cur[h] = NN; l_size[h] = 0;
    l_side[h] = pclm_pkg::SIDE_BEFORE;
  endfunction

  function int nx(int n); return n < NN ? n_next[n] : NN; endfunction
  function int pv(int n); return n < NN ? n_prev[n] : NN; endfunction
  function void snx(int n, int v); if (n < NN) n_next[n] = v; endfunction
  function void spv(int n, int v); if (n < NN) n_prev[n] = v; endfunction
  function logic [31:0] itm(int n); return n < NN ? n_item[n] : '0; endfunction

  function void drop_head(int h);
    wipe(h); h_live[h] = 0; h_next[h] = h_top; h_top = h;
  endfunction

  function void give(int n);
    if (n >= NN) return;
    n_next[n] = pool_top; n_prev[n] = NN; pool_top = n; pool_cnt++;
  endfunction

  function void link_in(int h, int n, logic [1:0] at);
    int c, a, b;
    c = l_cur[h];
    if (l_size[h] == 0) begin
      l_start[h] = n; l_end[h] = n;
    end else if (at == pclm_pkg::AT_FRONT) begin
      snx(n, l_start[h]); spv(l_start[h], n); l_start[h] = n;
    end else if (at == pclm_pkg::AT_BACK) begin
      spv(n, l_end[h]); snx(l_end[h], n); l_end[h] = n;
    end else if (at == pclm_pkg::AT_AFTER) begin
      a = nx(c); snx(n, a); spv(n, c); snx(c, n);
      if (a >= NN) l_end[h] = n; else spv(a, n);
    end else begin
      b = pv(c); spv(n, b); snx(n, c); spv(c, n);
      if (b >= NN) l_start[h] = n; else snx(b, n);
    end
    l_size[h]++; l_cur[h] = n; l_side[h] = pclm_pkg::SIDE_IN;
  endfunction

  function void note_command(pclm_pkg::req_t r);
    pclm_pkg::rsp_t o;
    int h, g, c, a, b, n, dest;
    logic [1:0] far_s, near_s, at;
    bit fwd;
    h = r.list_id; g = r.other_list;
    o = '0;
    if (r.command == pclm_pkg::CMD_CREATE) begin
      if (h_top >= NH) o.status = pclm_pkg::ST_NO_HEAD;
      else begin
        c = h_top; h_top = h_next[c]; h_live[c] = 1; wipe(c); o.handle_out = 4'(c);
      end
    end else if (!h_live[h] || r.command > pclm_pkg::CMD_FREE) begin
      o.status = pclm_pkg::ST_NONE;
    end else begin
      case (r.command)
        pclm_pkg::CMD_COUNT: ;
        pclm_pkg::CMD_FIRST, pclm_pkg::CMD_LAST: begin
          if (l_size[h] == 0) o.status = pclm_pkg::ST_NONE;
          else begin
            l_cur[h] = (r.command == pclm_pkg::CMD_FIRST) ? l_start[h] : l_end[h];
            l_side[h] = pclm_pkg::SIDE_IN; o.item_out = itm(l_cur[h]);
          end
        end
        pclm_pkg::CMD_NEXT, pclm_pkg::CMD_PREV: begin
          fwd = (r.command == pclm_pkg::CMD_NEXT);
          far_s = fwd ? pclm_pkg::SIDE_AFTER : pclm_pkg::SIDE_BEFORE;
          near_s = fwd ? pclm_pkg::SIDE_BEFORE : pclm_pkg::SIDE_AFTER;
          if (l_size[h] == 0 || l_side[h] == far_s) dest = NN;
          else if (l_side[h] == near_s) dest = fwd ? l_start[h] : l_end[h];
          else dest = fwd ? nx(l_cur[h]) : pv(l_cur[h]);
          if (dest >= NN) begin
            l_cur[h] = NN; l_side[h] = far_s; o.status = pclm_pkg::ST_NONE;
          end else begin
            l_cur[h] = dest; l_side[h] = pclm_pkg::SIDE_IN; o.item_out = itm(dest);
          end
        end
        pclm_pkg::CMD_CURR: begin
          if (l_size[h] == 0 || l_side[h] != pclm_pkg::SIDE_IN)
            o.status = pclm_pkg::ST_NONE;
          else o.item_out = itm(l_cur[h]);
        end
        pclm_pkg::CMD_INS_AFTER, pclm_pkg::CMD_INS_BEFORE,
        pclm_pkg::CMD_APPEND, pclm_pkg::CMD_PREPEND: begin
          if (pool_cnt == 0 || pool_top >= NN) o.status = pclm_pkg::ST_POOL_EMPTY;
          else begin
            n = pool_top; pool_top = n_next[n]; pool_cnt--;
            n_item[n] = r.item; n_next[n] = NN; n_prev[n] = NN;
            if (r.command == pclm_pkg::CMD_APPEND) at = pclm_pkg::AT_BACK;
            else if (r.command == pclm_pkg::CMD_PREPEND) at = pclm_pkg::AT_FRONT;
            else if (l_side[h] == pclm_pkg::SIDE_BEFORE) at = pclm_pkg::AT_FRONT;
            else if (l_side[h] == pclm_pkg::SIDE_AFTER) at = pclm_pkg::AT_BACK;
            else at = (r.command == pclm_pkg::CMD_INS_AFTER) ?
                      pclm_pkg::AT_AFTER : pclm_pkg::AT_BEFORE;
            link_in(h, n, at);
          end
        end
        pclm_pkg::CMD_REMOVE: begin
          if (l_size[h] == 0 || l_side[h] != pclm_pkg::SIDE_IN)
            o.status = pclm_pkg::ST_NONE;
          else begin
            c = l_cur[h]; b = pv(c); a = nx(c);
            if (b >= NN) l_start[h] = a; else snx(b, a);
            if (a >= NN) l_end[h] = b; else spv(a, b);
            l_size[h]--;
            if (a >= NN) begin
              l_cur[h] = NN; l_side[h] = pclm_pkg::SIDE_AFTER;
            end else l_cur[h] = a;
            o.item_out = itm(c); give(c);
          end
        end
        pclm_pkg::CMD_TRIM: begin
          if (l_size[h] == 0) o.status = pclm_pkg::ST_NONE;
          else begin
            c = l_end[h]; b = pv(c);
            if (b >= NN) l_start[h] = NN; else snx(b, NN);
            l_end[h] = b; l_size[h]--;
            if (l_size[h] == 0) begin
              l_cur[h] = NN; l_side[h] = pclm_pkg::SIDE_BEFORE;
            end else begin
              l_cur[h] = b; l_side[h] = pclm_pkg::SIDE_IN;
            end
            o.item_out = itm(c); give(c);
          end
        end
        pclm_pkg::CMD_CONCAT: begin
          if (g == h || !h_live[g]) o.status = pclm_pkg::ST_NONE;
          else begin
            if (l_size[g] != 0) begin
              if (l_size[h] == 0) l_start[h] = l_start[g];
              else begin
                snx(l_end[h], l_start[g]); spv(l_start[g], l_end[h]);
              end
              l_end[h] = l_end[g]; l_size[h] += l_size[g];
            end
            drop_head(g);
          end
        end
        default: begin
          if (l_size[h] != 0) begin
            snx(l_end[h], pool_top); spv(l_start[h], NN);
            pool_top = l_start[h]; pool_cnt += l_size[h];
          end
          drop_head(h);
        end
      endcase
    end
    if (r.command != pclm_pkg::CMD_CREATE && h_live[h]) o.count = 9'(l_size[h]);
    pending.push_back(o);
  endfunction

  function void check_result(pclm_pkg::rsp_t got);
    pclm_pkg::rsp_t e;
    if (pending.size() == 0) begin
      $error("result beat with nothing expected"); errors++; return;
    end
    e = pending.pop_front();
    if (got.status !== e.status) begin
      $error("status exp %0d got %0d", e.status, got.status); errors++;
    end
    if (got.item_out !== e.item_out) begin
      $error("item_out exp %h got %h", e.item_out, got.item_out); errors++;
    end
    if (got.handle_out !== e.handle_out) begin
      $error("handle_out exp %0d got %0d", e.handle_out, got.handle_out); errors++;
    end
    if (got.count !== e.count) begin
      $error("count exp %0d got %0d", e.count, got.count); errors++;
    end
  endfunction
endclass

module pooled_cursor_list_manager_core_tb;
  import pclm_pkg::*;

  localparam logic [3:0] CMD_UNUSED = 4'd15;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rsp_t rsp;
  bit quiet = 0;
  int n_issued = 0;

  list_scoreboard sb = new();

  pooled_cursor_list_manager_core dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
    .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_result(rsp);
  end

  // result side backpressure
  initial begin
    int k;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 0;
        k = $urandom_range(1, 14);
        repeat (k) @(negedge clk);
      end else begin
        rsp_ready <= 1;
        k = $urandom_range(1, 20);
        repeat (k) @(negedge clk);
      end
    end
  end

  task automatic send_cmd(logic [3:0] cmd, logic [3:0] id, logic [3:0] oth,
                          logic [31:0] it);
    req_t r;
    r.command = cmd; r.list_id = id; r.other_list = oth; r.item = it;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_valid <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    req <= r;
    req_valid <= 1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_command(r);
    n_issued++;
    @(negedge clk);
    req_valid <= 0;
    // the block is busy here, so this cycle costs no throughput
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_item();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] live_pick();
    for (int t = 0; t < 8; t++) begin
      int h;
      h = $urandom_range(0, 15);
      if (sb.h_live[h]) return 4'(h);
    end
    return 4'($urandom_range(0, 15));
  endfunction

  initial begin
    logic [3:0] cmd, h;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed
    send_cmd(CMD_COUNT, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_CREATE, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_FIRST, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_TRIM, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_NEXT, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_PREV, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_INS_AFTER, 4'd0, 4'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_INS_BEFORE, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_APPEND, 4'd0, 4'd0, 32'hA5A5_5A5A);
    send_cmd(CMD_PREPEND, 4'd0, 4'd0, 32'h5A5A_A5A5);
    send_cmd(CMD_LAST, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_NEXT, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_INS_BEFORE, 4'd0, 4'd0, 32'h1234_5678);
    send_cmd(CMD_CURR, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_REMOVE, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_REMOVE, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_CREATE, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_APPEND, 4'd1, 4'd0, 32'h0F0F_0F0F);
    send_cmd(CMD_CONCAT, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_CONCAT, 4'd0, 4'd1, 32'h0);
    send_cmd(CMD_UNUSED, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_TRIM, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_FREE, 4'd0, 4'd0, 32'h0);
    send_cmd(CMD_FREE, 4'd15, 4'd0, 32'h0);
    // exhaust heads
    repeat (17) send_cmd(CMD_CREATE, 4'($urandom), 4'($urandom), $urandom);
    // exhaust the node pool
    repeat (260) send_cmd(CMD_APPEND, live_pick(), 4'($urandom), rand_item());
    repeat (16) send_cmd(CMD_FREE, live_pick(), 4'($urandom), $urandom);
    // random mix, biased to live handles and inserts
    for (int i = 0; i < 600; i++) begin
      if (i > 520) quiet = 1;
      case ($urandom_range(0, 19))
        0, 1: cmd = CMD_CREATE;
        2: cmd = CMD_FREE;
        3: cmd = CMD_CONCAT;
        4, 5, 6, 7: cmd = 4'(CMD_INS_AFTER + $urandom_range(0, 3));
        8: cmd = CMD_UNUSED;
        default: cmd = 4'($urandom_range(1, 12));
      endcase
      h = ($urandom_range(0, 9) == 0) ? 4'($urandom) : live_pick();
      send_cmd(cmd, h, ($urandom_range(0, 3) == 0) ? 4'($urandom) : live_pick(),
               rand_item());
    end
    quiet = 1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("PASS pooled_cursor_list_manager_core");
    else $display("FAIL pooled_cursor_list_manager_core");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL pooled_cursor_list_manager_core");
    $finish;
  end
endmodule
